>>> hdl/flux_weakening_regulator_unit_defines.svh
// ----------------------------------------------------------------------------
// Flux weakening regulator - assertion macros
// Shared property wrappers for the concurrent checks in the regulator.
// ----------------------------------------------------------------------------
`ifndef FLUX_WEAKENING_REGULATOR_UNIT_DEFINES_SVH
`define FLUX_WEAKENING_REGULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FWR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FWR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/fwr_pkg.sv
// ----------------------------------------------------------------------------
// fwr_pkg
// Types, constants and microcode table of the flux weakening regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package fwr_pkg;

	// Microprogram counter
	localparam int unsigned UPC_W = 4;
	typedef logic [UPC_W-1:0] upc_t;

	// Microprogram addresses
	localparam upc_t UPC_GLO_MUL  = 4'd0;
	localparam upc_t UPC_GLO_DIV  = 4'd1;
	localparam upc_t UPC_GATE     = 4'd2;
	localparam upc_t UPC_KI_MUL   = 4'd3;
	localparam upc_t UPC_INTEG    = 4'd4;
	localparam upc_t UPC_PROP     = 4'd5;
	localparam upc_t UPC_VMAX2    = 4'd6;
	localparam upc_t UPC_SQINIT   = 4'd7;
	localparam upc_t UPC_SQSTEP   = 4'd8;
	localparam upc_t UPC_FINISH   = 4'd9;
	localparam upc_t UPC_RAMP     = 4'd10;

	// Configuration register indexes
	localparam logic [2:0] CFG_PROP_GAIN     = 3'd0;
	localparam logic [2:0] CFG_INTEG_GAIN    = 3'd1;
	localparam logic [2:0] CFG_BASE_SPEED    = 3'd2;
	localparam logic [2:0] CFG_VOLTAGE_MAX   = 3'd3;
	localparam logic [2:0] CFG_RECOVERY_RATE = 3'd4;

	// Fixed-point constants
	localparam logic [14:0] Q15_ONE        = 15'h7FFF;
	localparam logic [14:0] BASE_SPEED_RST = 15'd1000;
	localparam logic [14:0] RECOVERY_RST   = 15'd100;
	// 95/100 = 19/20: multiply by 19, shift by 2, then /5 by reciprocal (2^20/5 rounded up)
	localparam logic [17:0] MUL_C19        = 18'd19;
	localparam logic [17:0] RECIP5         = 18'd209716;
	// Square root produces 15 result bits, one per step
	localparam logic [3:0]  SQ_STEPS_M1    = 4'd14;

	// Multiplier operand selects
	typedef enum logic [2:0] {
		MA_ZERO, MA_BASE, MA_PQ, MA_IG, MA_PG, MA_VMAX, MA_VABS
	} mul_a_t;

	typedef enum logic [2:0] {
		MB_ZERO, MB_C19, MB_RECIP, MB_MAG, MB_VMAX, MB_VABS
	} mul_b_t;

	// Datapath actions
	typedef enum logic [3:0] {
		OP_NONE, OP_GATE, OP_INTEG, OP_PROP, OP_VMAX2,
		OP_SQINIT, OP_SQSTEP, OP_RAMP, OP_FINISH
	} dp_op_t;

	// Sequencing of the next step
	typedef enum logic [2:0] {
		JMP_NEXT, JMP_ALWAYS, JMP_IF_RAMP, JMP_IF_NOROOT, JMP_LOOP, JMP_WAIT_OUT
	} jump_t;

	typedef enum logic {
		SEQ_IDLE, SEQ_RUN
	} seq_state_t;

	// One control word
	typedef struct packed {
		mul_a_t  ma;
		mul_b_t  mb;
		logic    mul_en;
		dp_op_t  op;
		jump_t   jmp;
		upc_t    target;
	} uword_t;

	// Sequencer to datapath
	typedef struct packed {
		logic   start;
		logic   run;
		uword_t uw;
	} seq_ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic take_ramp;
		logic no_root;
		logic sq_done;
		logic out_free;
	} dp_stat_t;

	function automatic uword_t uw_make(mul_a_t ma, mul_b_t mb, logic men, dp_op_t op,
			jump_t jmp, upc_t tgt);
		uword_t w;
		w.ma     = ma;
		w.mb     = mb;
		w.mul_en = men;
		w.op     = op;
		w.jmp    = jmp;
		w.target = tgt;
		return w;
	endfunction

	// Microprogram
	function automatic uword_t ucode_rom(upc_t pc);
		uword_t w;
		case (pc)
			UPC_GLO_MUL: w = uw_make(MA_BASE, MB_C19, 1'b1, OP_NONE, JMP_NEXT, UPC_GLO_MUL);
			UPC_GLO_DIV: w = uw_make(MA_PQ, MB_RECIP, 1'b1, OP_NONE, JMP_NEXT, UPC_GLO_MUL);
			UPC_GATE:    w = uw_make(MA_ZERO, MB_ZERO, 1'b0, OP_GATE, JMP_IF_RAMP, UPC_RAMP);
			UPC_KI_MUL:  w = uw_make(MA_IG, MB_MAG, 1'b1, OP_NONE, JMP_NEXT, UPC_GLO_MUL);
			UPC_INTEG:   w = uw_make(MA_PG, MB_MAG, 1'b1, OP_INTEG, JMP_NEXT, UPC_GLO_MUL);
			UPC_PROP:    w = uw_make(MA_VMAX, MB_VMAX, 1'b1, OP_PROP, JMP_NEXT, UPC_GLO_MUL);
			UPC_VMAX2:   w = uw_make(MA_VABS, MB_VABS, 1'b1, OP_VMAX2, JMP_NEXT, UPC_GLO_MUL);
			UPC_SQINIT:  w = uw_make(MA_ZERO, MB_ZERO, 1'b0, OP_SQINIT, JMP_IF_NOROOT,
					UPC_FINISH);
			UPC_SQSTEP:  w = uw_make(MA_ZERO, MB_ZERO, 1'b0, OP_SQSTEP, JMP_LOOP, UPC_SQSTEP);
			UPC_FINISH:  w = uw_make(MA_ZERO, MB_ZERO, 1'b0, OP_FINISH, JMP_WAIT_OUT,
					UPC_FINISH);
			UPC_RAMP:    w = uw_make(MA_ZERO, MB_ZERO, 1'b0, OP_RAMP, JMP_ALWAYS, UPC_FINISH);
			default:     w = uw_make(MA_ZERO, MB_ZERO, 1'b0, OP_NONE, JMP_ALWAYS, UPC_FINISH);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> hdl/fwr_in_if.sv
// ----------------------------------------------------------------------------
// fwr_in_if
// Sample channel: one control tick of measurements per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwr_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] vd_sample;
	logic signed [15:0] limit_scale;
	logic signed [15:0] id_base;
	logic signed [15:0] rotor_speed;

	modport source (
		output valid, vd_sample, limit_scale, id_base, rotor_speed,
		input  ready
	);

	modport sink (
		input  valid, vd_sample, limit_scale, id_base, rotor_speed,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/fwr_out_if.sv
// ----------------------------------------------------------------------------
// fwr_out_if
// Result channel: current addition, q-current limit and activity flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwr_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] id_add;
	logic        [14:0] iq_limit;
	logic               weakening_active;

	modport source (
		output valid, id_add, iq_limit, weakening_active,
		input  ready
	);

	modport sink (
		input  valid, id_add, iq_limit, weakening_active,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/fwr_seq.sv
// ----------------------------------------------------------------------------
// fwr_seq
// Microprogram sequencer: step counter, control word fetch, jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire fwr_pkg::dp_stat_t stat,
	output fwr_pkg::seq_ctrl_t    ctrl,
	output logic                  busy
);
	import fwr_pkg::*;

	seq_state_t state_q, state_nx;
	upc_t       pc_q, pc_nx;
	uword_t     uw;
	upc_t       pc_inc;

	// Control word fetch
	assign uw     = ucode_rom(pc_q);
	assign pc_inc = pc_q + upc_t'(1);

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			pc_q    <= UPC_GLO_MUL;
		end else begin
			state_q <= state_nx;
			pc_q    <= pc_nx;
		end
	end

	// Next step selection
	always_comb begin
		state_nx = state_q;
		pc_nx    = pc_q;
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_nx = SEQ_RUN;
					pc_nx    = UPC_GLO_MUL;
				end
			end
			SEQ_RUN: begin
				case (uw.jmp)
					JMP_NEXT:      pc_nx = pc_inc;
					JMP_ALWAYS:    pc_nx = uw.target;
					JMP_IF_RAMP:   pc_nx = stat.take_ramp ? uw.target : pc_inc;
					JMP_IF_NOROOT: pc_nx = stat.no_root ? uw.target : pc_inc;
					JMP_LOOP:      pc_nx = stat.sq_done ? pc_inc : uw.target;
					JMP_WAIT_OUT: begin
						if (stat.out_free)
							state_nx = SEQ_IDLE;
					end
					default:       state_nx = SEQ_IDLE;
				endcase
			end
			default: state_nx = SEQ_IDLE;
		endcase
	end

	// Datapath control
	always_comb begin
		ctrl.start = start && (state_q == SEQ_IDLE);
		ctrl.run   = (state_q == SEQ_RUN);
		ctrl.uw    = uw;
	end

	assign busy = (state_q != SEQ_IDLE);

endmodule

`default_nettype wire

>>> hdl/fwr_dp.sv
// ----------------------------------------------------------------------------
// fwr_dp
// Regulator datapath: shared multiplier, integrator, speed gate, square root.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fwr_pkg::seq_ctrl_t ctrl,
	output fwr_pkg::dp_stat_t       stat,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_idx,
	input  wire logic [14:0]        cfg_wdata,
	// request fields
	input  wire logic signed [15:0] vd_in,
	input  wire logic signed [15:0] scale_in,
	input  wire logic signed [15:0] idb_in,
	input  wire logic signed [15:0] spd_in,
	// result
	input  wire logic               out_rdy,
	output logic                    out_vld,
	output logic signed [15:0]      id_add,
	output logic [14:0]             iq_limit,
	output logic                    active
);
	import fwr_pkg::*;

	// configuration registers
	logic [14:0] kp_q, ki_q, base_q, vmax_q, rr_q;
	// latched request
	logic [14:0] vabs_q, scale_q, lob_q;
	logic [15:0] sabs_q;
	// working state
	logic [35:0] p_q;
	logic signed [16:0] acc_q;
	logic        gate_q;
	logic [14:0] t_q;
	logic [29:0] x_q;
	logic [16:0] rem_q;
	logic [14:0] root_q;
	logic [3:0]  cnt_q;
	logic signed [15:0] id_q;
	logic [14:0] iq_q;
	logic        act_q;
	// output register
	logic        out_vld_q;
	logic signed [15:0] id_o_q;
	logic [14:0] iq_o_q;
	logic        act_o_q;

	logic [15:0] vd_neg, spd_neg;
	logic [14:0] vabs_in, scale_cl, lob_in;
	logic [15:0] sabs_in;
	logic [17:0] mul_a, mul_b;
	logic [14:0] mag, glo, vd2, diff;
	logic        gate_nx;
	logic [30:0] trm_sum;
	logic [15:0] term;
	logic signed [17:0] acc_ext, integ_sum, prop_sum, ramp_sum;
	logic signed [16:0] integ_acc, prop_id, ramp_acc;
	logic [18:0] rem_sh, trial, rem_sub;
	logic        ge;
	logic [16:0] rem_nx;
	logic [14:0] root_nx;
	logic        fin_load;

	// Clamp to [-lob, 0]
	function automatic logic signed [16:0] clamp_lob(logic signed [17:0] x, logic [14:0] lob);
		logic signed [17:0] lo;
		lo = -$signed({3'b000, lob});
		if (x < lo)
			return lo[16:0];
		else if (x > 18'sd0)
			return 17'sd0;
		else
			return x[16:0];
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= '0;
			ki_q   <= '0;
			base_q <= BASE_SPEED_RST;
			vmax_q <= '0;
			rr_q   <= RECOVERY_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PROP_GAIN:     kp_q   <= cfg_wdata;
				CFG_INTEG_GAIN:    ki_q   <= cfg_wdata;
				CFG_BASE_SPEED:    base_q <= cfg_wdata;
				CFG_VOLTAGE_MAX:   vmax_q <= cfg_wdata;
				CFG_RECOVERY_RATE: rr_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Request conditioning: magnitudes and clamps
	always_comb begin
		vd_neg  = 16'(-vd_in);
		spd_neg = 16'(-spd_in);
		if (!vd_in[15])
			vabs_in = vd_in[14:0];
		else if (vd_in == 16'sh8000)
			vabs_in = Q15_ONE;
		else
			vabs_in = vd_neg[14:0];
		scale_cl = scale_in[15] ? 15'd0 : scale_in[14:0];
		lob_in   = (!idb_in[15] && idb_in != 16'sd0) ? idb_in[14:0] : 15'd0;
		sabs_in  = spd_in[15] ? spd_neg : spd_in;
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			vabs_q  <= vabs_in;
			scale_q <= scale_cl;
			lob_q   <= lob_in;
			sabs_q  <= sabs_in;
		end
	end

	assign mag = Q15_ONE - scale_q;

	// Shared multiplier operands
	always_comb begin
		case (ctrl.uw.ma)
			MA_BASE: mul_a = {3'b000, base_q};
			MA_PQ:   mul_a = p_q[19:2];
			MA_IG:   mul_a = {3'b000, ki_q};
			MA_PG:   mul_a = {3'b000, kp_q};
			MA_VMAX: mul_a = {3'b000, vmax_q};
			MA_VABS: mul_a = {3'b000, vabs_q};
			default: mul_a = '0;
		endcase
		case (ctrl.uw.mb)
			MB_C19:   mul_b = MUL_C19;
			MB_RECIP: mul_b = RECIP5;
			MB_MAG:   mul_b = {3'b000, mag};
			MB_VMAX:  mul_b = {3'b000, vmax_q};
			MB_VABS:  mul_b = {3'b000, vabs_q};
			default:  mul_b = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.run && ctrl.uw.mul_en)
			p_q <= mul_a * mul_b;
	end

	// Speed gate with hysteresis; lower threshold is base*19/20
	always_comb begin
		glo = p_q[34:20];
		if (sabs_q >= {1'b0, base_q})
			gate_nx = 1'b1;
		else if (sabs_q < {1'b0, glo})
			gate_nx = 1'b0;
		else
			gate_nx = gate_q;
	end

	// Q15 product magnitude rounded up: negated, this is floor of the signed term
	assign trm_sum = {1'b0, p_q[29:0]} + 31'd32767;
	assign term    = trm_sum[30:15];

	// Integrator, proportional sum and recovery ramp
	always_comb begin
		acc_ext   = {acc_q[16], acc_q};
		integ_sum = acc_ext - $signed({2'b00, term});
		integ_acc = clamp_lob(integ_sum, lob_q);
		prop_sum  = acc_ext - $signed({2'b00, term});
		prop_id   = clamp_lob(prop_sum, lob_q);
		ramp_sum  = acc_ext + $signed({3'b000, rr_q});
		if (!acc_q[16])
			ramp_acc = acc_q;
		else if (ramp_sum > 18'sd0)
			ramp_acc = 17'sd0;
		else
			ramp_acc = ramp_sum[16:0];
	end

	// Voltage headroom
	assign vd2  = p_q[29:15];
	assign diff = t_q - vd2;

	// One restoring square root step
	always_comb begin
		rem_sh  = {rem_q, x_q[29:28]};
		trial   = {2'b00, root_q, 2'b01};
		ge      = (rem_sh >= trial);
		rem_sub = rem_sh - trial;
		rem_nx  = ge ? rem_sub[16:0] : rem_sh[16:0];
		root_nx = {root_q[13:0], ge};
	end

	// Status to the sequencer
	always_comb begin
		stat.take_ramp = !gate_nx || (scale_q == Q15_ONE);
		stat.no_root   = (vmax_q == 15'd0) || (vd2 >= t_q);
		stat.sq_done   = (cnt_q == 4'd0);
		stat.out_free  = !out_vld_q || out_rdy;
	end

	assign fin_load = ctrl.run && (ctrl.uw.op == OP_FINISH) && stat.out_free;

	// Loop state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			gate_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (ctrl.run) begin
				case (ctrl.uw.op)
					OP_GATE:  gate_q <= gate_nx;
					OP_INTEG: acc_q  <= integ_acc;
					OP_RAMP:  acc_q  <= ramp_acc;
					default: ;
				endcase
			end
			if (fin_load)
				out_vld_q <= 1'b1;
			else if (out_rdy)
				out_vld_q <= 1'b0;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (ctrl.run) begin
			case (ctrl.uw.op)
				OP_INTEG: act_q <= 1'b1;
				OP_PROP:  id_q  <= prop_id[15:0];
				OP_VMAX2: t_q   <= p_q[29:15];
				OP_SQINIT: begin
					if (stat.no_root)
						iq_q <= '0;
					x_q    <= {diff, 15'd0};
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= SQ_STEPS_M1;
				end
				OP_SQSTEP: begin
					rem_q  <= rem_nx;
					root_q <= root_nx;
					x_q    <= {x_q[27:0], 2'b00};
					cnt_q  <= cnt_q - 4'd1;
					if (cnt_q == 4'd0)
						iq_q <= root_nx;
				end
				OP_RAMP: begin
					id_q  <= ramp_acc[15:0];
					iq_q  <= Q15_ONE;
					act_q <= 1'b0;
				end
				default: ;
			endcase
		end
		if (fin_load) begin
			id_o_q  <= id_q;
			iq_o_q  <= iq_q;
			act_o_q <= act_q;
		end
	end

	assign out_vld  = out_vld_q;
	assign id_add   = id_o_q;
	assign iq_limit = iq_o_q;
	assign active   = act_o_q;

endmodule

`default_nettype wire

>>> hdl/flux_weakening_regulator_unit.sv
// ----------------------------------------------------------------------------
// flux_weakening_regulator_unit
// Flux weakening PI regulator with speed gate and q-current limit.
// ----------------------------------------------------------------------------
// Usage:
//  - sample channel: one request per control tick (vd, saturation scale,
//    base d-current, rotor speed). ready is high while the sequencer is idle.
//  - result channel: id_add, iq_limit, weakening_active, held in an output
//    register until taken.
//  - configuration: cfg_we/cfg_idx/cfg_wdata, written while idle.
// Sequencing:
//  - a request runs a short microprogram on one shared 18x18 multiplier.
//    Recovery path (gate open or no saturation): threshold, gate, ramp, load.
//    PI path: PI terms and 15 root steps (none at zero limit), no ramp.
//    A new request is taken the cycle after the result is loaded.
//  - the square root (one result bit per cycle) sets the PI path length.
// Reset: gains and voltage_max clear, base_speed 1000, recovery_rate 100,
//  integrator zero, gate open, no result pending.
// Stall: a result waiting on ready holds the sequencer in its final step;
//  the next request is then not taken until the result leaves.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flux_weakening_regulator_unit_defines.svh"

module flux_weakening_regulator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	fwr_in_if.sink           sample,
	fwr_out_if.source        result,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [14:0] cfg_wdata
);
	import fwr_pkg::*;

	seq_ctrl_t ctrl;
	dp_stat_t  stat;
	logic      busy;
	logic      start;

	// Request handshake
	assign sample.ready = !busy;
	assign start        = sample.valid && !busy;

	fwr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	fwr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.vd_in     (sample.vd_sample),
		.scale_in  (sample.limit_scale),
		.idb_in    (sample.id_base),
		.spd_in    (sample.rotor_speed),
		.out_rdy   (result.ready),
		.out_vld   (result.valid),
		.id_add    (result.id_add),
		.iq_limit  (result.iq_limit),
		.active    (result.weakening_active)
	);

	// Checks
	`FWR_ASSERT_NEXT(a_busy_after_req, clk, arst_n, sample.valid && sample.ready, !sample.ready, "request accepted but sequencer still ready")
	`FWR_ASSERT_SAME(a_id_nonpos, clk, arst_n, result.valid, result.id_add[15] || result.id_add == 16'sd0, "positive d-current addition")
	`FWR_ASSERT_SAME(a_idle_full_limit, clk, arst_n, result.valid && !result.weakening_active, result.iq_limit == Q15_ONE, "q-limit not full while weakening inactive")

endmodule

`default_nettype wire
